FILE: src/kdsl_pkg.sv
// shared types, widths and codes for the key debounce short/long press unit
`default_nettype none
package kdsl_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int CFG_WIDTH   = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_MAX     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEXT_TRACK_EN = 2'd3;

  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = 16'd40;
  localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = 16'd400;
  localparam logic [CFG_WIDTH-1:0] SHORT_MAX_RESET  = 16'd400;

  localparam logic [2:0] ACT_NONE        = 3'd0;
  localparam logic [2:0] ACT_VOL_DOWN    = 3'd1;
  localparam logic [2:0] ACT_NEXT_TRACK  = 3'd2;
  localparam logic [2:0] ACT_WAKE_UNLOCK = 3'd3;
  localparam logic [2:0] ACT_CLOSE_MENU  = 3'd4;
  localparam logic [2:0] ACT_OPEN_MENU   = 3'd5;

  localparam logic [1:0] APP_MUSIC  = 2'd1;
  localparam logic [1:0] APP_EBOOK  = 2'd2;
  localparam logic [1:0] PWR_NORMAL = 2'd0;

  typedef struct packed {
    logic       menu_is_open;
    logic [1:0] screen_power;
    logic       screen_locked;
    logic [1:0] foreground_app;
    logic       raw_level_pressed;
  } tick_t;

  typedef struct packed {
    logic       key_stable;
    logic       user_activity;
    logic [2:0] action;
  } result_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] debounce_ticks;
    logic [CFG_WIDTH-1:0] long_press_ticks;
    logic [CFG_WIDTH-1:0] short_max_ticks;
    logic                 next_track_en;
  } cfg_t;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    sat_inc = (&v) ? v : v + COUNT_WIDTH'(1);
  endfunction

endpackage
`default_nettype wire

FILE: src/kdsl_cfg_regs.sv
// configuration register file with write port
`default_nettype none
module kdsl_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [kdsl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [kdsl_pkg::CFG_WIDTH-1:0] cfg_data,
  output kdsl_pkg::cfg_t                     cfg
);
  import kdsl_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks   <= DEBOUNCE_RESET;
      cfg.long_press_ticks <= LONG_PRESS_RESET;
      cfg.short_max_ticks  <= SHORT_MAX_RESET;
      cfg.next_track_en    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE:      cfg.debounce_ticks   <= cfg_data;
        REG_LONG_PRESS:    cfg.long_press_ticks <= cfg_data;
        REG_SHORT_MAX:     cfg.short_max_ticks  <= cfg_data;
        REG_NEXT_TRACK_EN: cfg.next_track_en    <= cfg_data[0];
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: src/kdsl_in_reg.sv
// input register stage for tick beats
`default_nettype none
module kdsl_in_reg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output      logic                            s_tready,
  input  wire logic [kdsl_pkg::IN_TDATA_W-1:0] s_tdata,
  input  wire logic                            advance,
  output      logic                            tick_valid,
  output      kdsl_pkg::tick_t                 tick
);
  import kdsl_pkg::*;

  assign s_tready = !tick_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (s_tready) begin
      tick_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      tick <= tick_t'(s_tdata[$bits(tick_t)-1:0]);
    end
  end
endmodule
`default_nettype wire

FILE: src/kdsl_core.sv
// debounce and press state, action decode and result register
`default_nettype none
module kdsl_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire kdsl_pkg::cfg_t                   cfg,
  input  wire logic                             tick_valid,
  input  wire kdsl_pkg::tick_t                  tick,
  output      logic                             advance,
  output      logic                             m_tvalid,
  input  wire logic                             m_tready,
  output      logic [kdsl_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import kdsl_pkg::*;

  logic                   initialized, raw_last, stable_pressed, armed;
  logic                   press_timing, long_fired;
  logic [COUNT_WIDTH-1:0] ticks_since_change, hold_ticks;

  logic                   initialized_next, raw_last_next, stable_pressed_next, armed_next;
  logic                   press_timing_next, long_fired_next;
  logic [COUNT_WIDTH-1:0] ticks_since_change_next, hold_ticks_next;
  result_t                res_next, res;
  logic                   fire;

  assign advance = !m_tvalid || m_tready;
  assign fire    = tick_valid && advance;

  always_comb begin
    initialized_next        = 1'b1;
    raw_last_next           = raw_last;
    stable_pressed_next     = stable_pressed;
    armed_next              = armed;
    press_timing_next       = press_timing;
    long_fired_next         = long_fired;
    ticks_since_change_next = sat_inc(ticks_since_change);
    hold_ticks_next         = press_timing ? sat_inc(hold_ticks) : hold_ticks;
    res_next                = '0;
    res_next.action         = ACT_NONE;

    if (!initialized) begin
      raw_last_next           = tick.raw_level_pressed;
      stable_pressed_next     = tick.raw_level_pressed;
      ticks_since_change_next = '0;
      hold_ticks_next         = '0;
      press_timing_next       = 1'b0;
      long_fired_next         = 1'b0;
      armed_next              = !tick.raw_level_pressed;
    end else if (tick.raw_level_pressed != raw_last) begin
      raw_last_next           = tick.raw_level_pressed;
      ticks_since_change_next = '0;
    end else if (tick.raw_level_pressed != stable_pressed) begin
      if (ticks_since_change_next >= cfg.debounce_ticks) begin
        stable_pressed_next = tick.raw_level_pressed;
        if (!tick.raw_level_pressed) begin
          if (!armed) begin
            armed_next = 1'b1;
          end else if (press_timing && hold_ticks_next <= cfg.short_max_ticks) begin
            if (!cfg.next_track_en) begin
              res_next.action = ACT_VOL_DOWN;
            end else if (tick.foreground_app == APP_MUSIC ||
                         tick.foreground_app == APP_EBOOK) begin
              res_next.action = ACT_NEXT_TRACK;
            end
          end
          press_timing_next = 1'b0;
          long_fired_next   = 1'b0;
        end else if (armed) begin
          press_timing_next      = 1'b1;
          hold_ticks_next        = '0;
          long_fired_next        = 1'b0;
          res_next.user_activity = 1'b1;
        end
      end
    end else if (armed && stable_pressed && press_timing && !long_fired &&
                 hold_ticks_next >= cfg.long_press_ticks) begin
      long_fired_next = 1'b1;
      priority if (tick.screen_locked || tick.screen_power != PWR_NORMAL) begin
        res_next.action = ACT_WAKE_UNLOCK;
      end else if (tick.menu_is_open) begin
        res_next.action = ACT_CLOSE_MENU;
      end else if (tick.foreground_app == APP_MUSIC) begin
        res_next.action = ACT_OPEN_MENU;
      end else begin
        res_next.action = ACT_NONE;
      end
    end

    res_next.key_stable = stable_pressed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      initialized        <= 1'b0;
      raw_last           <= 1'b0;
      stable_pressed     <= 1'b0;
      armed              <= 1'b0;
      press_timing       <= 1'b0;
      long_fired         <= 1'b0;
      ticks_since_change <= '0;
      hold_ticks         <= '0;
    end else if (fire) begin
      initialized        <= initialized_next;
      raw_last           <= raw_last_next;
      stable_pressed     <= stable_pressed_next;
      armed              <= armed_next;
      press_timing       <= press_timing_next;
      long_fired         <= long_fired_next;
      ticks_since_change <= ticks_since_change_next;
      hold_ticks         <= hold_ticks_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

  assign m_tdata = OUT_TDATA_W'(res);
endmodule
`default_nettype wire

FILE: src/key_debounce_short_long_press_unit.sv
// Key debouncer with short and long press detection. One tick beat enters per
// clock cycle while m_tready does not hold the output, and gives exactly one
// result beat via the input register and then the result register, with the state
// updated between them. Configuration writes take effect at once and are meant
// to be made while no beat is in flight.
`default_nettype none
module key_debounce_short_long_press_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [kdsl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [kdsl_pkg::CFG_WIDTH-1:0]   cfg_data,
  input  wire logic                             s_tvalid,
  output      logic                             s_tready,
  // raw_level_pressed, foreground_app[1:0], screen_locked, screen_power[1:0],
  // menu_is_open, pad
  input  wire logic [kdsl_pkg::IN_TDATA_W-1:0]  s_tdata,
  output      logic                             m_tvalid,
  input  wire logic                             m_tready,
  // action[2:0], user_activity, key_stable, pad[2:0]
  output      logic [kdsl_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import kdsl_pkg::*;

  cfg_t  cfg;
  tick_t tick;
  logic  tick_valid;
  logic  advance;

  kdsl_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kdsl_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .advance    (advance),
    .tick_valid (tick_valid),
    .tick       (tick)
  );

  kdsl_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .tick_valid (tick_valid),
    .tick       (tick),
    .advance    (advance),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );
endmodule
`default_nettype wire

FILE: dv/testbench.sv
// self-checking stream testbench for the key debounce short/long press unit
`timescale 1ns / 100ps
module testbench;
  import kdsl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_DEBOUNCE;
  logic [CFG_WIDTH-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  key_debounce_short_long_press_unit u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #1 clk = ~clk;

  // register shadows
  logic [CFG_WIDTH-1:0] debounce_limit = DEBOUNCE_RESET;
  logic [CFG_WIDTH-1:0] long_limit = LONG_PRESS_RESET;
  logic [CFG_WIDTH-1:0] short_limit = SHORT_MAX_RESET;
  logic track_sel = 1'b0;

  // debouncer state
  logic key_init = 1'b0;
  logic key_raw = 1'b0;
  logic key_level = 1'b0;
  logic key_armed = 1'b0;
  logic key_timing = 1'b0;
  logic key_long_done = 1'b0;
  logic [COUNT_WIDTH-1:0] since_change = '0;
  logic [COUNT_WIDTH-1:0] hold_count = '0;

  tick_t ticks_to_send[$];
  result_t results_due[$];
  int unsigned errors = 0;
  int unsigned idle_mode = 2;
  logic hold_off_req = 1'b0;

  function automatic logic [COUNT_WIDTH-1:0] count_up(input logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic result_t advance_tick(input tick_t t);
    result_t r;
    r = '0;
    if (!key_init) begin
      key_raw = t.raw_level_pressed;
      key_level = t.raw_level_pressed;
      since_change = '0;
      hold_count = '0;
      key_timing = 1'b0;
      key_long_done = 1'b0;
      key_armed = !t.raw_level_pressed;
      key_init = 1'b1;
    end else begin
      since_change = count_up(since_change);
      if (key_timing) hold_count = count_up(hold_count);
      if (t.raw_level_pressed != key_raw) begin
        key_raw = t.raw_level_pressed;
        since_change = '0;
      end else if (t.raw_level_pressed != key_level) begin
        if (since_change >= debounce_limit) begin
          key_level = t.raw_level_pressed;
          if (!t.raw_level_pressed) begin
            if (!key_armed) begin
              key_armed = 1'b1;
            end else if (key_timing && hold_count <= short_limit) begin
              if (!track_sel) r.action = ACT_VOL_DOWN;
              else if (t.foreground_app == APP_MUSIC || t.foreground_app == APP_EBOOK)
                r.action = ACT_NEXT_TRACK;
            end
            key_timing = 1'b0;
            key_long_done = 1'b0;
          end else if (key_armed) begin
            key_timing = 1'b1;
            hold_count = '0;
            key_long_done = 1'b0;
            r.user_activity = 1'b1;
          end
        end
      end else if (key_armed && key_level && key_timing && !key_long_done &&
                   hold_count >= long_limit) begin
        key_long_done = 1'b1;
        if (t.screen_locked || t.screen_power != PWR_NORMAL) r.action = ACT_WAKE_UNLOCK;
        else if (t.menu_is_open) r.action = ACT_CLOSE_MENU;
        else if (t.foreground_app == APP_MUSIC) r.action = ACT_OPEN_MENU;
      end
    end
    r.key_stable = key_level;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (idle_mode == 0) return 0;
    if (idle_mode == 1) return (roll < 3) ? $urandom_range(1, 2) : 0;
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // sender
  int unsigned tx_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) results_due.push_back(advance_tick(tick_t'(s_tdata[6:0])));
      if (!s_tvalid || s_tready) begin
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
          s_tvalid <= 1'b0;
        end else if (ticks_to_send.size() != 0) begin
          s_tdata <= {1'b0, ticks_to_send.pop_front()};
          s_tvalid <= 1'b1;
          tx_gap <= pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  int unsigned rx_gap = 0;
  int unsigned hold_off_left = 0;
  logic hold_off_done = 1'b0;
  result_t want, got;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_gap <= 0;
      hold_off_left <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[4:0]);
        if (results_due.size() == 0) begin
          $error("result beat with nothing expected: %0h", m_tdata);
          errors = errors + 1;
        end else begin
          want = results_due.pop_front();
          if (got.action !== want.action) begin
            $error("action: expected %0d, got %0d", want.action, got.action);
            errors = errors + 1;
          end
          if (got.user_activity !== want.user_activity) begin
            $error("user_activity: expected %0d, got %0d", want.user_activity,
                   got.user_activity);
            errors = errors + 1;
          end
          if (got.key_stable !== want.key_stable) begin
            $error("key_stable: expected %0d, got %0d", want.key_stable, got.key_stable);
            errors = errors + 1;
          end
        end
      end
      if (hold_off_left != 0) begin
        hold_off_left <= hold_off_left - 1;
        m_tready <= 1'b0;
      end else if (hold_off_req && !hold_off_done) begin
        hold_off_left <= HOLD_OFF_CYCLES;
        hold_off_done <= 1'b1;
        m_tready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap <= rx_gap - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        rx_gap <= pick_gap();
      end
    end
  end

  int unsigned cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("key_debounce_short_long_press_unit: mismatch");
      $finish;
    end
  end

  task automatic push_tick(input logic raw, input logic [1:0] app, input logic locked,
                           input logic [1:0] power, input logic menu);
    tick_t t;
    t.raw_level_pressed = raw;
    t.foreground_app = app;
    t.screen_locked = locked;
    t.screen_power = power;
    t.menu_is_open = menu;
    ticks_to_send.push_back(t);
  endtask

  task automatic push_random_ctx(input logic raw);
    push_tick(raw, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
              2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
  endtask

  task automatic push_press_runs(input int unsigned n);
    int unsigned count;
    int unsigned len;
    int unsigned span;
    logic level;
    count = 0;
    level = 1'($urandom_range(0, 1));
    span = debounce_limit + long_limit + 6;
    while (count < n) begin
      if ($urandom_range(0, 4) != 0) level = ~level;
      len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, span);
      repeat (len) push_random_ctx(level);
      count = count + len;
    end
  endtask

  task automatic settle();
    do @(negedge clk);
    while (ticks_to_send.size() != 0 || s_tvalid || results_due.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_WIDTH-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_DEBOUNCE: debounce_limit = val;
      REG_LONG_PRESS: long_limit = val;
      REG_SHORT_MAX: short_limit = val;
      REG_NEXT_TRACK_EN: track_sel = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [CFG_WIDTH-1:0] deb, input logic [CFG_WIDTH-1:0] lng,
                                input logic [CFG_WIDTH-1:0] sht, input logic trk);
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_LONG_PRESS, lng);
    write_reg(REG_SHORT_MAX, sht);
    write_reg(REG_NEXT_TRACK_EN, {15'd0, trk});
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [CFG_WIDTH-1:0] deb, lng, sht;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // first tick held, unarmed release, short press, locked long press
    apply_settings(16'd0, 16'd2, 16'd2, 1'b0);
    push_tick(1'b1, 2'd0, 1'b0, 2'd0, 1'b0);
    push_tick(1'b1, 2'd3, 1'b0, 2'd3, 1'b1);
    push_tick(1'b0, 2'd0, 1'b0, 2'd0, 1'b0);
    push_tick(1'b0, 2'd0, 1'b0, 2'd0, 1'b0);
    push_tick(1'b1, 2'd2, 1'b0, 2'd0, 1'b0);
    push_tick(1'b1, 2'd2, 1'b0, 2'd0, 1'b0);
    push_tick(1'b0, 2'd2, 1'b0, 2'd0, 1'b0);
    push_tick(1'b0, 2'd2, 1'b0, 2'd0, 1'b0);
    repeat (4) push_tick(1'b1, 2'd1, 1'b1, 2'd0, 1'b0);
    push_tick(1'b1, 2'd1, 1'b0, 2'd0, 1'b0);
    push_tick(1'b0, 2'd1, 1'b0, 2'd0, 1'b0);
    push_tick(1'b0, 2'd1, 1'b0, 2'd0, 1'b0);
    settle();

    // next track on e-book, close menu on long press
    apply_settings(16'd0, 16'd1, 16'd2, 1'b1);
    push_tick(1'b1, 2'd2, 1'b0, 2'd0, 1'b0);
    push_tick(1'b1, 2'd2, 1'b0, 2'd0, 1'b0);
    push_tick(1'b0, 2'd2, 1'b0, 2'd0, 1'b0);
    push_tick(1'b0, 2'd2, 1'b0, 2'd0, 1'b0);
    repeat (3) push_tick(1'b1, 2'd0, 1'b0, 2'd0, 1'b1);
    repeat (2) push_tick(1'b0, 2'd0, 1'b0, 2'd0, 1'b0);
    settle();

    for (int k = 0; k < 8; k++) begin
      case ($urandom_range(0, 3))
        0: deb = 16'd0;
        default: deb = 16'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 3))
        0: lng = 16'd0;
        1: lng = 16'd1;
        default: lng = 16'($urandom_range(2, 30));
      endcase
      case ($urandom_range(0, 3))
        0: sht = 16'd0;
        1: sht = 16'd1;
        default: sht = 16'($urandom_range(2, 30));
      endcase
      apply_settings(deb, lng, sht, 1'(k % 2));
      idle_mode = (k == 0) ? 2 : $urandom_range(0, 2);
      if (k == 1) hold_off_req <= 1'b1;
      push_press_runs(100);
      settle();
    end

    // release and arm before the long hold run
    idle_mode = 2;
    apply_settings(16'd0, 16'd0, 16'd0, 1'b0);
    repeat (4) push_random_ctx(1'b0);
    settle();

    // thresholds at maximum: a long hold stays below every threshold
    idle_mode = 1;
    apply_settings(16'hffff, 16'hffff, 16'hffff, 1'b1);
    repeat (100) push_random_ctx(1'b1);
    settle();

    apply_settings(16'd0, 16'hffff, 16'hffff, 1'b1);
    repeat (3) push_tick(1'b0, 2'd1, 1'b0, 2'd0, 1'b0);
    settle();

    idle_mode = 2;
    apply_settings(16'd1, 16'd4, 16'd3, 1'b0);
    push_press_runs(60);
    settle();

    if (errors == 0) begin
      $display("key_debounce_short_long_press_unit: match");
    end else begin
      $display("key_debounce_short_long_press_unit: mismatch");
    end
    $finish;
  end

endmodule
